>>> rtl/telemetry_unit_convert_freshness_macros.svh
// assertion helpers for the telemetry converter
`ifndef TELEMETRY_UNIT_CONVERT_FRESHNESS_MACROS_SVH
`define TELEMETRY_UNIT_CONVERT_FRESHNESS_MACROS_SVH
`ifndef SYNTHESIS
`define TUCF_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define TUCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TUCF_ASSERT(label, expr, msg)
`define TUCF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/tucf_pkg.sv
package tucf_pkg;

	// sensor identifiers
	localparam logic [15:0] ID_COORD   = 16'h0800;
	localparam logic [15:0] ID_GPS_ALT = 16'h0820;
	localparam logic [15:0] ID_SPEED   = 16'h0830;
	localparam logic [15:0] ID_COURSE  = 16'h0840;
	localparam logic [15:0] ID_VOLT    = 16'h0210;
	localparam logic [15:0] ID_CURR    = 16'h0200;
	localparam logic [15:0] ID_FUEL    = 16'h0600;
	localparam logic [15:0] ID_ALT     = 16'h0100;
	localparam logic [15:0] ID_VSPD    = 16'h0110;

	typedef enum logic [3:0] {
		OP_COORD,
		OP_GPS_ALT,
		OP_SPEED,
		OP_COURSE,
		OP_VOLT,
		OP_CURR,
		OP_FUEL,
		OP_ALT,
		OP_VSPD
	} op_t;

	typedef enum logic [1:0] {
		KIND_GPS   = 2'd0,
		KIND_BATT  = 2'd1,
		KIND_VARIO = 2'd2,
		KIND_BARO  = 2'd3
	} kind_t;

	// reciprocal multipliers, exact floor division over the operand range used
	localparam logic [31:0] RECIP_DEG   = 32'd1125899907; // /1000000, 30-bit, shift 50
	localparam int          SH_DEG      = 50;
	localparam logic [31:0] RECIP_TEN   = 32'd3435973837; // /10, shift 35
	localparam int          SH_TEN      = 35;
	localparam logic [31:0] RECIP_HUN   = 32'd2748779070; // /100, shift 38
	localparam int          SH_HUN      = 38;
	localparam logic [31:0] RECIP_TTH   = 32'd3518437209; // /10000, shift 45
	localparam int          SH_TTH      = 45;
	localparam logic [14:0] THIRD_MUL   = 15'd21846;      // /3 for 15-bit, shift 16

	localparam logic [31:0] SPEED_MUL   = 32'd1852;
	localparam logic [31:0] CENTI_MUL   = 32'd100;
	localparam logic [19:0] DEG_SCALE   = 20'd1000000;
	localparam logic [31:0] COORD_SCALE = 32'd10000000;
	localparam logic [19:0] MIN_STEP    = 20'd10000;
	localparam logic [23:0] MIN_WHOLE   = 24'd166666;     // integer part of 1e7/60
	localparam logic [15:0] GPS_ALT_OFS = 16'd1000;
	localparam logic [15:0] BARO_OFS    = 16'd10000;
	localparam logic [31:0] TIMEOUT_RST = 32'd1000000;

	localparam int IN_W  = 80;
	localparam int OUT_W = 184;

	// floor(x / 3) for any 15-bit x
	function automatic logic [13:0] third15(input logic [14:0] x);
		logic [30:0] p;
		p = 31'(x) * 31'(THIRD_MUL);
		return p[29:16];
	endfunction

	function automatic kind_t op_kind(input op_t op);
		kind_t k;
		unique case (op) inside
			OP_COORD, OP_GPS_ALT, OP_SPEED, OP_COURSE: k = KIND_GPS;
			OP_VOLT, OP_CURR, OP_FUEL:                 k = KIND_BATT;
			OP_VSPD:                                   k = KIND_VARIO;
			default:                                   k = KIND_BARO;
		endcase
		return k;
	endfunction

endpackage

>>> rtl/telemetry_unit_convert_freshness.sv
// channel   | dir | tdata (low bit up)                                      | tuser
// ----------+-----+---------------------------------------------------------+-----------
// s_*       | in  | sensor_id 16, sensor_value 32, now_us 32                | -
// m_*       | out | latitude 32, longitude 32, ground_speed 16, heading 16, | frame_kind
//           |     | gnss_altitude 16, voltage_mv 16, current_ma 16,         |
//           |     | remaining 8, climb_rate 16, baro_altitude 16            |
// cfg_*     | in  | stale_timeout_us 32 on cfg_wr_data                      | -
//
// one beat per clock sustained while m_tready drains the output; results pass stages s1..s5 then the output register
// the pipeline is built around the two shared multipliers (five stages + output register)
// unknown ids are consumed and drop out; a zero timeout drops every result
// each stage holds while the stage after it is full and stalled, so bubbles still fill
// asynchronous active-low reset clears valids, stored fields and loads the default timeout

`include "telemetry_unit_convert_freshness_macros.svh"

module telemetry_unit_convert_freshness (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [31:0]                cfg_wr_data,    // stale_timeout_us
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [tucf_pkg::IN_W-1:0]  s_tdata,        // sensor_id, sensor_value, now_us
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [tucf_pkg::OUT_W-1:0] m_tdata,        // latitude, longitude, ground_speed,
	                                                   // heading, gnss_altitude, voltage_mv,
	                                                   // current_ma, remaining,
	                                                   // climb_rate, baro_altitude
	output logic [1:0]                 m_tuser         // frame_kind
);

	// unpacked input fields
	logic [15:0] sensor_id;
	logic [31:0] sensor_value;

	assign sensor_id    = s_tdata[15:0];
	assign sensor_value = s_tdata[47:16];
	// a group is stamped with the arrival time and checked in the same beat, so its age is
	// always zero; freshness reduces to a nonzero timeout and the time field is not needed

	logic [31:0] stale_timeout_q;
	logic        timeout_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_timeout_q <= tucf_pkg::TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			stale_timeout_q <= cfg_wr_data;
		end
	end

	assign timeout_zero = (stale_timeout_q == 32'd0);

	// stage handshake: a stage takes a new beat when it is empty or moving on
	logic v_s1, v_s2, v_s3, v_s4, v_s5, vo_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;

	assign rdy_o    = !vo_q || m_tready;
	assign rdy5     = !v_s5 || rdy_o;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;
	assign m_tvalid = vo_q;

	// id decode
	logic            in_known;
	tucf_pkg::op_t   in_op;

	always_comb begin
		in_known = 1'b1;
		in_op    = tucf_pkg::OP_COORD;
		unique case (sensor_id)
			tucf_pkg::ID_COORD:   in_op = tucf_pkg::OP_COORD;
			tucf_pkg::ID_GPS_ALT: in_op = tucf_pkg::OP_GPS_ALT;
			tucf_pkg::ID_SPEED:   in_op = tucf_pkg::OP_SPEED;
			tucf_pkg::ID_COURSE:  in_op = tucf_pkg::OP_COURSE;
			tucf_pkg::ID_VOLT:    in_op = tucf_pkg::OP_VOLT;
			tucf_pkg::ID_CURR:    in_op = tucf_pkg::OP_CURR;
			tucf_pkg::ID_FUEL:    in_op = tucf_pkg::OP_FUEL;
			tucf_pkg::ID_ALT:     in_op = tucf_pkg::OP_ALT;
			tucf_pkg::ID_VSPD:    in_op = tucf_pkg::OP_VSPD;
			default:              in_known = 1'b0;
		endcase
	end

	// stage payloads
	tucf_pkg::op_t op_s1, op_s2, op_s3, op_s4, op_s5;
	logic [31:0]   val_s1, val_s2;
	logic [63:0]   prod_s2;
	logic          sign_s3, sign_s4, sign_s5;
	logic          lon_s3, lon_s4, lon_s5;
	logic [19:0]   rem_s3, rem_s4;
	logic [31:0]   deg_term_s3, deg_term_s4, deg_term_s5;
	logic [15:0]   small_s3, small_s4, small_s5;
	logic [31:0]   spd_s3;
	logic [63:0]   prod2_s4;
	logic [13:0]   frac_s5;
	logic [23:0]   min_term_s5;

	// first shared multiplier: reciprocal or scale factor picked by the id
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_a;

	always_comb begin
		mul_a = val_s1;
		mul_b = tucf_pkg::RECIP_TEN;
		unique case (op_s1) inside
			tucf_pkg::OP_COORD: begin
				mul_a = {2'b00, val_s1[29:0]};
				mul_b = tucf_pkg::RECIP_DEG;
			end
			tucf_pkg::OP_COURSE:                 mul_b = tucf_pkg::RECIP_HUN;
			tucf_pkg::OP_SPEED:                  mul_b = tucf_pkg::SPEED_MUL;
			tucf_pkg::OP_VOLT, tucf_pkg::OP_CURR: mul_b = tucf_pkg::CENTI_MUL;
			default:                             mul_b = tucf_pkg::RECIP_TEN;
		endcase
		prod_a = 64'(mul_a) * 64'(mul_b);
	end

	// degrees split off, simple fields finished
	logic [10:0] deg_b;
	logic [30:0] deg_mil_b;
	logic [29:0] rem_full_b;
	logic [31:0] deg_term_b;
	logic [15:0] small_b;

	always_comb begin
		deg_b      = prod_s2[tucf_pkg::SH_DEG +: 11];
		deg_mil_b  = 31'(deg_b) * 31'(tucf_pkg::DEG_SCALE);
		rem_full_b = val_s2[29:0] - deg_mil_b[29:0];
		deg_term_b = 32'(deg_b) * tucf_pkg::COORD_SCALE;
		small_b    = '0;
		case (op_s2) inside
			tucf_pkg::OP_GPS_ALT:
				small_b = prod_s2[tucf_pkg::SH_TEN +: 16] + tucf_pkg::GPS_ALT_OFS;
			tucf_pkg::OP_ALT:                    small_b = prod_s2[tucf_pkg::SH_TEN +: 16];
			tucf_pkg::OP_COURSE:                 small_b = prod_s2[tucf_pkg::SH_HUN +: 16];
			tucf_pkg::OP_VOLT, tucf_pkg::OP_CURR: small_b = prod_s2[15:0];
			tucf_pkg::OP_FUEL:                   small_b = {8'h00, val_s2[7:0]};
			tucf_pkg::OP_VSPD:                   small_b = val_s2[15:0];
			default:                             small_b = '0;
		endcase
	end

	// second shared multiplier: divide by 10000 for minutes or for speed
	logic [31:0] mul2_a;
	logic [63:0] prod2_c;

	assign mul2_a  = (op_s3 == tucf_pkg::OP_COORD) ? {12'h000, rem_s3} : spd_s3;
	assign prod2_c = 64'(mul2_a) * 64'(tucf_pkg::RECIP_TTH);

	// whole minutes, minute fraction, minutes scaled to 1e-7 degrees
	logic [6:0]  min_d;
	logic [19:0] min_step_d;
	logic [19:0] frac_full_d;
	logic [23:0] min_term_d;
	logic [15:0] small_d;

	always_comb begin
		min_d       = prod2_s4[tucf_pkg::SH_TTH +: 7];
		min_step_d  = 20'(min_d) * tucf_pkg::MIN_STEP;
		frac_full_d = rem_s4 - min_step_d;
		min_term_d  = 24'(min_d) * tucf_pkg::MIN_WHOLE
			+ 24'(tucf_pkg::third15({7'd0, min_d, 1'b0}));
		small_d     = (op_s4 == tucf_pkg::OP_SPEED) ? prod2_s4[tucf_pkg::SH_TTH +: 16]
			: small_s4;
	end

	// coordinate sum and sign
	logic [17:0] frac_term_e;
	logic [31:0] coord_sum_e;
	logic [31:0] coord_e;

	always_comb begin
		frac_term_e = {frac_s5, 4'h0} + 18'(tucf_pkg::third15({frac_s5, 1'b0}));
		coord_sum_e = deg_term_s5 + 32'(min_term_s5) + 32'(frac_term_e);
		coord_e     = sign_s5 ? (32'd0 - coord_sum_e) : coord_sum_e;
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid && in_known;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage payloads, no reset
	always_ff @(posedge clk) begin
		if (rdy1) begin
			op_s1  <= in_op;
			val_s1 <= sensor_value;
		end
		if (rdy2) begin
			op_s2   <= op_s1;
			val_s2  <= val_s1;
			prod_s2 <= prod_a;
		end
		if (rdy3) begin
			op_s3       <= op_s2;
			sign_s3     <= val_s2[30];
			lon_s3      <= val_s2[31];
			rem_s3      <= rem_full_b[19:0];
			deg_term_s3 <= deg_term_b;
			small_s3    <= small_b;
			spd_s3      <= prod_s2[31:0];
		end
		if (rdy4) begin
			op_s4       <= op_s3;
			sign_s4     <= sign_s3;
			lon_s4      <= lon_s3;
			rem_s4      <= rem_s3;
			deg_term_s4 <= deg_term_s3;
			small_s4    <= small_s3;
			prod2_s4    <= prod2_c;
		end
		if (rdy5) begin
			op_s5       <= op_s4;
			sign_s5     <= sign_s4;
			lon_s5      <= lon_s4;
			frac_s5     <= frac_full_d[13:0];
			min_term_s5 <= min_term_d;
			deg_term_s5 <= deg_term_s4;
			small_s5    <= small_d;
		end
	end

	// stored fields: written in order as each beat reaches the output register
	logic [31:0] lat_q, lon_q;
	logic [15:0] speed_q, heading_q, galt_q, volt_q, curr_q, alt_q, vspd_q;
	logic [7:0]  fuel_q;

	logic [31:0] lat_n, lon_n;
	logic [15:0] speed_n, heading_n, galt_n, volt_n, curr_n, alt_n, vspd_n;
	logic [7:0]  fuel_n;

	always_comb begin
		lat_n     = lat_q;
		lon_n     = lon_q;
		speed_n   = speed_q;
		heading_n = heading_q;
		galt_n    = galt_q;
		volt_n    = volt_q;
		curr_n    = curr_q;
		fuel_n    = fuel_q;
		alt_n     = alt_q;
		vspd_n    = vspd_q;
		unique case (op_s5)
			tucf_pkg::OP_COORD: begin
				if (lon_s5) begin
					lon_n = coord_e;
				end else begin
					lat_n = coord_e;
				end
			end
			tucf_pkg::OP_GPS_ALT: galt_n    = small_s5;
			tucf_pkg::OP_SPEED:   speed_n   = small_s5;
			tucf_pkg::OP_COURSE:  heading_n = small_s5;
			tucf_pkg::OP_VOLT:    volt_n    = small_s5;
			tucf_pkg::OP_CURR:    curr_n    = small_s5;
			tucf_pkg::OP_FUEL:    fuel_n    = small_s5[7:0];
			tucf_pkg::OP_ALT:     alt_n     = small_s5;
			tucf_pkg::OP_VSPD:    vspd_n    = small_s5;
			default:              lat_n     = lat_q;
		endcase
	end

	// result frame, fields outside the frame kind stay zero
	tucf_pkg::kind_t           kind_e;
	logic [tucf_pkg::OUT_W-1:0] frame_e;

	always_comb begin
		kind_e  = tucf_pkg::op_kind(op_s5);
		frame_e = '0;
		case (kind_e)
			tucf_pkg::KIND_GPS: begin
				frame_e[31:0]   = lat_n;
				frame_e[63:32]  = lon_n;
				frame_e[79:64]  = speed_n;
				frame_e[95:80]  = heading_n;
				frame_e[111:96] = galt_n;
			end
			tucf_pkg::KIND_BATT: begin
				frame_e[127:112] = volt_n;
				frame_e[143:128] = curr_n;
				frame_e[151:144] = fuel_n;
			end
			tucf_pkg::KIND_VARIO: begin
				frame_e[167:152] = vspd_n;
			end
			default: begin
				frame_e[167:152] = vspd_n;
				frame_e[183:168] = alt_n + tucf_pkg::BARO_OFS;
			end
		endcase
	end

	logic adv_o;
	assign adv_o = v_s5 && rdy_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q      <= 1'b0;
			lat_q     <= '0;
			lon_q     <= '0;
			speed_q   <= '0;
			heading_q <= '0;
			galt_q    <= '0;
			volt_q    <= '0;
			curr_q    <= '0;
			fuel_q    <= '0;
			alt_q     <= '0;
			vspd_q    <= '0;
		end else begin
			if (rdy_o) vo_q <= v_s5 && !timeout_zero;
			if (adv_o) begin
				lat_q     <= lat_n;
				lon_q     <= lon_n;
				speed_q   <= speed_n;
				heading_q <= heading_n;
				galt_q    <= galt_n;
				volt_q    <= volt_n;
				curr_q    <= curr_n;
				fuel_q    <= fuel_n;
				alt_q     <= alt_n;
				vspd_q    <= vspd_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_o) begin
			m_tdata <= frame_e;
			m_tuser <= kind_e;
		end
	end

	`TUCF_ASSERT_NEXT(a_out_from_s5, !vo_q && !v_s5, !vo_q, "result without a finished beat")
	`TUCF_ASSERT_NEXT(a_zero_timeout, !vo_q && timeout_zero, !vo_q, "result with zero timeout")
	`TUCF_ASSERT(a_gps_only, !vo_q || m_tuser == tucf_pkg::KIND_GPS || ~|m_tdata[111:0], "gps leak")
	`TUCF_ASSERT(a_stall_full, s_tready || v_s1, "input stalled with empty first stage")

endmodule
